// ===== rtl/ffca_pkg.sv =====
// ============================================================================
// ffca_pkg
// Shared types and constants of the first-fit contiguous block allocator.
// ============================================================================
package ffca_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int MAX_FILES  = 64;

    // block number and run length / block count widths
    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int FILE_W = $clog2(MAX_FILES + 1);

    // result field widths
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 6;
    localparam int REQ_W    = 7;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_TOTAL_BLOCKS = '0;
    localparam logic [CNT_W-1:0]  TOTAL_BLOCKS_RST = CNT_W'(NUM_BLOCKS);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // scan token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] run_len;
        logic [BLK_W-1:0] run_start;
        logic             hit;
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] last;
    } tok_t;

    // broadcast command that marks a run of blocks used
    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] last;
    } mark_t;

endpackage

// ===== rtl/ffca_cell.sv =====
// ============================================================================
// ffca_cell
// One disk block: holds its used bit and advances the scan token one step.
// ============================================================================
module ffca_cell
    import ffca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [BLK_W-1:0] cell_index,
    input  logic [CNT_W-1:0] req_size,
    input  logic [CNT_W-1:0] limit,
    input  mark_t            mark,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic used_reg;
    logic used_next;
    tok_t tok_reg;
    tok_t tok_next;
    logic in_range;
    logic [CNT_W-1:0] len_inc;

    assign in_range = {1'b0, cell_index} < limit;
    assign len_inc  = tok_in.run_len + CNT_W'(1);

    // extend or break the free run, flag the first fit
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && in_range)
        begin
            if (used_reg)
            begin
                tok_next.run_len = '0;
            end
            else
            begin
                tok_next.run_len = len_inc;
                if (tok_in.run_len == '0)
                begin
                    tok_next.run_start = cell_index;
                end
                if (len_inc == req_size)
                begin
                    tok_next.hit   = 1'b1;
                    tok_next.first = tok_next.run_start;
                    tok_next.last  = cell_index;
                end
            end
        end
    end

    // mark the block used when it falls inside the granted run
    always_comb
    begin
        used_next = used_reg;
        if (mark.valid && cell_index >= mark.first && cell_index <= mark.last)
        begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/ffca_ctrl.sv =====
// ============================================================================
// ffca_ctrl
// Request sequencer: launches the scan, marks the run, holds the result.
// ============================================================================
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] request_size
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [7:2] start_block,
                                              // [13:8] end_block, [19:14] file_index
    output logic [CNT_W-1:0]       req_size,
    output tok_t                   tok_head,
    input  tok_t                   tok_tail,
    output mark_t                  mark
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MARK = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic                  inject_reg, inject_next;
    logic [FILE_W-1:0]     files_reg, files_next;
    logic [CNT_W-1:0]      size_reg, size_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [BLK_W-1:0]      res_first_reg, res_first_next;
    logic [BLK_W-1:0]      res_last_reg, res_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                  accept;
    logic                  out_free;
    logic [REQ_W-1:0]      in_size;

    assign in_size  = s_tdata[REQ_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        inject_next     = 1'b0;
        files_next      = files_reg;
        size_next       = size_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        mark            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    size_next      = CNT_W'(in_size);
                    res_first_next = '0;
                    res_last_next  = '0;
                    if (files_reg >= FILE_W'(MAX_FILES))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = ST_RESP;
                    end
                    else if (in_size == '0 || in_size > REQ_W'(NUM_BLOCKS))
                    begin
                        res_status_next = ST_NOSPACE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        inject_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // wait for the token to leave the last cell
                if (tok_tail.valid)
                begin
                    if (tok_tail.hit)
                    begin
                        res_status_next = ST_OK;
                        res_first_next  = tok_tail.first;
                        res_last_next   = tok_tail.last;
                        state_next      = ST_MARK;
                    end
                    else
                    begin
                        res_status_next = ST_NOSPACE;
                        state_next      = ST_RESP;
                    end
                end
            end
            ST_MARK:
            begin
                mark.valid = 1'b1;
                mark.first = res_first_reg;
                mark.last  = res_last_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[1:0]   = res_status_reg;
                    out_data_next[7:2]   = FIELD_W'(res_first_reg);
                    out_data_next[13:8]  = FIELD_W'(res_last_reg);
                    if (res_status_reg == ST_OK)
                    begin
                        out_data_next[19:14] = FIELD_W'(files_reg);
                        files_next           = files_reg + FILE_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inject_reg    <= 1'b0;
            files_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inject_reg    <= inject_next;
            files_reg     <= files_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        out_data_reg   <= out_data_next;
    end

    // launch a fresh token into block zero
    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = inject_reg;
    end

    assign req_size = size_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/first_fit_contiguous_allocator.sv =====
// Sequence: a request is scanned by a token walking the row of block cells one cell per
//   cycle; a granted run is then marked, and the result is registered. A zero size, a size
//   above NUM_BLOCKS or a full table skips the scan and goes straight to the result.
// Only one request is in flight: no new request is taken until its result is registered.
// Reset: all blocks free, file count zero, total_blocks back to 64; no clearing pass.
// ============================================================================
// first_fit_contiguous_allocator
// First-fit contiguous disk block allocator built from a chain of block cells.
// ============================================================================
module first_fit_contiguous_allocator
    import ffca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] request_size
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [7:2] start_block,
                                              // [13:8] end_block, [19:14] file_index
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [CNT_W-1:0] total_blocks_reg, total_blocks_next;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] req_size;
    logic             reg_hit;
    mark_t            mark;
    tok_t             tok_chain [NUM_BLOCKS+1];

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_TOTAL_BLOCKS);

    always_comb
    begin
        total_blocks_next = total_blocks_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            total_blocks_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= TOTAL_BLOCKS_RST;
        end
        else
        begin
            total_blocks_reg <= total_blocks_next;
        end
    end

    assign prdata = reg_hit ? DATA_W'(total_blocks_reg) : '0;

    // clamp the scanned block count
    assign limit = (total_blocks_reg > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                            : total_blocks_reg;

    ffca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .req_size (req_size),
        .tok_head (tok_chain[0]),
        .tok_tail (tok_chain[NUM_BLOCKS]),
        .mark     (mark)
    );

    // row of block cells
    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_cell
        ffca_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (BLK_W'(g)),
            .req_size   (req_size),
            .limit      (limit),
            .mark       (mark),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1])
        );
    end

endmodule

// ===== rtl/ffca_checker.sv =====
// ============================================================================
// ffca_checker
// Port-level checks of the allocator's handshake and result encoding.
// ============================================================================
module ffca_checker
    import ffca_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // drop ready after taking a request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no status code beyond table full
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_NOSPACE ||
                      m_tdata[1:0] == ST_FULL))
        else $error("bad status code");

    // zero fields on a failed request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[19:2] == '0)
        else $error("nonzero fields on failure");

    // granted run never ends before it starts
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_OK |-> m_tdata[13:8] >= m_tdata[7:2])
        else $error("run end before start");

endmodule

bind first_fit_contiguous_allocator ffca_checker u_ffca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
